@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the pattern search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define BPS_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Types, constants and helpers shared by the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Default sizes
    localparam int BUFFER_SIZE_DEF = 262144;
    localparam int MAX_PATTERN_DEF = 16;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * BYTE_W;
    localparam int LEN_W     = 5;
    localparam int OFFSET_W  = 19;
    localparam int START_W   = 18;
    localparam int ADDR_W    = 18;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_LENGTH       = 3'd2,
        CFG_OFFSET       = 3'd3,
        CFG_START        = 3'd4,
        CFG_BACKWARD     = 3'd5
    } cfg_reg_t;

    // Pattern byte j out of the packed pattern, byte 0 in the low bits
    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                       input int j);
        return pat[j*BYTE_W +: BYTE_W];
    endfunction

endpackage

@@ rtl/bps_byte_if.sv @@
// ----------------------------------------------------------------------------
// bps_byte_if
// Valid/ready channel carrying one buffer byte per transfer.
// ----------------------------------------------------------------------------
interface bps_byte_if;
    logic                       valid;
    logic                       ready;
    logic [bps_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/bps_result_if.sv @@
// ----------------------------------------------------------------------------
// bps_result_if
// Valid/ready channel carrying one search result per transfer.
// ----------------------------------------------------------------------------
interface bps_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [bps_pkg::ADDR_W-1:0] result_address;

    modport source (output valid, output found, output result_address, input ready);
    modport sink   (input valid, input found, input result_address, output ready);
endinterface

@@ rtl/byte_pattern_search.sv @@
// Usage: bytes of a buffer arrive on the stream channel, one per transfer, in
// ascending address order; last_byte marks the final byte. Exactly one result
// transfer follows each last byte: found and result_address (match start plus
// the signed offset, zero when not found). Other bytes give no result.
// Registers are written through cfg_write_en / cfg_index / cfg_data while the
// block is idle; they take effect on the next byte.
// Throughput: one byte per cycle, sustained while no last byte waits on an
// unaccepted result, set by the window compare and match tracking stage.
// A last byte passes the input register, then the output register, to its result.
// The stream side holds one input register; when a result waits unaccepted,
// plain bytes keep flowing, and a further last byte waits in the input
// register until the result is taken.
// Reset clears the configuration, the window, the position counter and the
// match tracking; after each last byte the stream state clears for the next
// buffer.
// ----------------------------------------------------------------------------
// byte_pattern_search
// Streaming search of a byte buffer for a configured pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_pattern_search #(
    parameter int BUFFER_SIZE = bps_pkg::BUFFER_SIZE_DEF,
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
    bps_byte_if.sink                       stream,
    bps_result_if.source                   result
);

    localparam int PW = $clog2(BUFFER_SIZE + 1);
    localparam int CW = (PW > bps_pkg::START_W) ? PW : bps_pkg::START_W;
    localparam int SW = CW + 2;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int BW = bps_pkg::BYTE_W;

    // Configuration registers
    logic [bps_pkg::PAT_W-1:0]    pattern_reg;
    logic [bps_pkg::LEN_W-1:0]    length_reg;
    logic [bps_pkg::OFFSET_W-1:0] offset_reg;
    logic [bps_pkg::START_W-1:0]  start_reg;
    logic                         backward_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            length_reg   <= '0;
            offset_reg   <= '0;
            start_reg    <= '0;
            backward_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (bps_pkg::cfg_reg_t'(cfg_index))
                bps_pkg::CFG_PATTERN_LOW:
                    pattern_reg[bps_pkg::PAT_W/2-1:0] <= cfg_data;
                bps_pkg::CFG_PATTERN_HIGH:
                    pattern_reg[bps_pkg::PAT_W-1:bps_pkg::PAT_W/2] <= cfg_data;
                bps_pkg::CFG_LENGTH:   length_reg   <= cfg_data[bps_pkg::LEN_W-1:0];
                bps_pkg::CFG_OFFSET:   offset_reg   <= cfg_data[bps_pkg::OFFSET_W-1:0];
                bps_pkg::CFG_START:    start_reg    <= cfg_data[bps_pkg::START_W-1:0];
                bps_pkg::CFG_BACKWARD: backward_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    logic          s1_valid_reg;
    logic [BW-1:0] s1_byte_reg;
    logic          s1_last_reg;
    logic          s1_fire;
    logic          out_valid_reg;

    assign s1_fire      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg <= stream.data_byte;
            s1_last_reg <= stream.last_byte;
        end
    end

    // Stream state
    logic [BW-1:0] win_reg [MAX_PATTERN];
    logic [BW-1:0] win_cur [MAX_PATTERN];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          seen_reg;
    logic          seen_next;
    logic [CW-1:0] start_pos_reg;
    logic [CW-1:0] start_pos_next;

    // Window with the current byte shifted in; index 0 is the newest byte
    always_comb
    begin
        win_cur[0] = s1_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_cur[k] = win_reg[k-1];
        end
    end

    // Compare against every possible pattern length at once
    logic [MAX_PATTERN:0] len_hit;

    always_comb
    begin
        len_hit = '0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            len_hit[l] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (win_cur[l-1-j] != bps_pkg::pattern_byte(pattern_reg, j))
                begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // Match start decision
    logic          len_ok;
    logic          hit;
    logic          in_buf;
    logic          filled;
    logic [CW:0]   pos_plus1;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] cand_start;
    logic [CW-1:0] start_ext;
    logic [CW-1:0] size_less_len;
    logic [CW-1:0] limit;
    logic          take;

    always_comb
    begin
        len_ok        = (length_reg != '0) && (length_reg <= bps_pkg::LEN_W'(MAX_PATTERN));
        hit           = len_ok && len_hit[length_reg[LW-1:0]];
        len_ext       = CW'(length_reg);
        start_ext     = CW'(start_reg);
        pos_plus1     = (CW+1)'(pos_reg) + (CW+1)'(1);
        in_buf        = pos_reg < PW'(BUFFER_SIZE);
        filled        = pos_plus1 >= (CW+1)'(length_reg);
        cand_start    = pos_plus1[CW-1:0] - len_ext;
        size_less_len = CW'(BUFFER_SIZE) - len_ext;
        limit         = (start_ext > size_less_len) ? size_less_len : start_ext;
        take          = s1_fire && hit && in_buf && filled &&
                        (backward_reg ? (cand_start <= limit)
                                      : (!seen_reg && (cand_start >= start_ext)));
    end

    // Result address and range check
    logic          seen_cur;
    logic [CW-1:0] start_cur;
    logic [SW-1:0] addr_sum;
    logic          found_cur;

    always_comb
    begin
        seen_cur  = seen_reg || take;
        start_cur = take ? cand_start : start_pos_reg;
        addr_sum  = {2'b00, start_cur} +
                    {{(SW-bps_pkg::OFFSET_W){offset_reg[bps_pkg::OFFSET_W-1]}}, offset_reg};
        found_cur = seen_cur && len_ok && !addr_sum[SW-1] &&
                    (addr_sum[SW-2:0] < (SW-1)'(BUFFER_SIZE));
    end

    // Next stream state: clear after the last byte, else track
    always_comb
    begin
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        start_pos_next = start_pos_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                pos_next       = '0;
                seen_next      = 1'b0;
                start_pos_next = '0;
            end
            else
            begin
                pos_next       = in_buf ? pos_plus1[PW-1:0] : pos_reg;
                seen_next      = seen_cur;
                start_pos_next = start_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            start_pos_reg <= '0;
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            start_pos_reg <= start_pos_next;
            if (s1_fire)
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                begin
                    win_reg[k] <= s1_last_reg ? '0 : win_cur[k];
                end
            end
        end
    end

    // Output register
    logic                       found_reg;
    logic [bps_pkg::ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            found_reg <= found_cur;
            addr_reg  <= found_cur ? addr_sum[bps_pkg::ADDR_W-1:0] : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = found_reg;
    assign result.result_address = addr_reg;

    // Checks
    `BPS_ASSERT(a_clear_after_last, s1_fire && s1_last_reg |=> pos_reg == '0 && !seen_reg, "stream state not cleared after last byte")
    `BPS_ASSERT_NEVER(a_pos_bound, pos_reg > PW'(BUFFER_SIZE), "position counter past buffer size")
    `BPS_ASSERT(a_notfound_zero, out_valid_reg && !found_reg |-> addr_reg == '0, "nonzero address without a match")
    `BPS_ASSERT(a_last_waits, s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready |=> s1_valid_reg && out_valid_reg, "last byte lost while result stalled")

endmodule
